// ===== sv/selective_repeat_receive_window_unit_assert.svh =====
// ----------------------------------------------------------------------------
// selective repeat receive window assertion macros
// property wrappers on clk_i with an active-low reset disable
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_RECEIVE_WINDOW_UNIT_ASSERT_SVH
`define SELECTIVE_REPEAT_RECEIVE_WINDOW_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SRRW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srrw assertion failed");

// antecedent implies consequent in the next cycle
`define SRRW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srrw assertion failed");

`endif

// ===== sv/srrw_pkg.sv =====
// ----------------------------------------------------------------------------
// srrw_pkg
// shared types and constants of the selective repeat receive window
// ----------------------------------------------------------------------------
`default_nettype none

package srrw_pkg;

  // sequence space, a power of two so that counters wrap by themselves
  localparam int SEQ_W     = 3;
  localparam int SEQ_SPACE = 2 ** SEQ_W;
  localparam int BYTE_W    = 8;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [SEQ_W-1:0]  seq_number;
    logic [BYTE_W-1:0] payload;
  } frame_t;

  typedef struct packed {
    logic              deliver_valid;
    logic [BYTE_W-1:0] deliver_byte;
    logic              accepted;
    logic [SEQ_W-1:0]  ack_number;
    logic              last;
  } result_t;

  typedef struct packed {
    logic              accepted;
    logic [SEQ_W-1:0]  seq;
    logic [BYTE_W-1:0] data;
  } q_entry_t;

  typedef struct packed {
    logic [SEQ_W-1:0] expected_seq;
    logic [SEQ_W-1:0] window_end;
    logic             frame_done;
  } win_status_t;

endpackage

`default_nettype wire

// ===== sv/selective_repeat_receive_window_unit.sv =====
// ----------------------------------------------------------------------------
// selective_repeat_receive_window_unit
// selective repeat receive window with reorder store and in-order release
// ----------------------------------------------------------------------------
// rejected frame: popped and marked done in idle, then its result is registered in emit
// accepted frame releasing n bytes: the scan state moves the window over the filled slots,
//   then marks the frame done so the next frame can be accepted; results then follow
// each of the n bytes is read from the registered reorder store, then emitted, and emit
//   waits while the output is stalled; the back end pops no new frame before idle
// reset: window at [0, WINDOW_SIZE), all slots empty, no result pending
`default_nettype none

module selective_repeat_receive_window_unit #(
  parameter int WINDOW_SIZE = 4
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  srrw_pkg::frame_t   in_word_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output srrw_pkg::result_t  out_word_o
);
  import srrw_pkg::*;

  `include "selective_repeat_receive_window_unit_assert.svh"

  win_status_t            status;
  logic [WINDOW_SIZE-1:0] slot_filled;
  logic                   q_push;
  logic                   q_full;
  logic                   q_pop;
  logic                   q_valid;
  q_entry_t               q_in;
  q_entry_t               q_out;

  srrw_front #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_word_i     (in_word_i),
    .status_i      (status),
    .slot_filled_i (slot_filled),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_entry_o     (q_in)
  );

  srrw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_out)
  );

  srrw_back #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_entry_i     (q_out),
    .q_pop_o       (q_pop),
    .status_o      (status),
    .slot_filled_o (slot_filled),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_word_o    (out_word_o)
  );

  `SRRW_ASSERT_NXT(a_one_frame_in_flight, clk_i, rst_ni, q_push, in_stall_o)
  `SRRW_ASSERT_IMP(a_no_push_when_full, clk_i, rst_ni, q_push, !q_full)
  `SRRW_ASSERT_IMP(a_window_width, clk_i, rst_ni, 1'b1,
                   (status.window_end - status.expected_seq) == SEQ_W'(WINDOW_SIZE % SEQ_SPACE))

endmodule

`default_nettype wire

// ===== sv/srrw_front.sv =====
// ----------------------------------------------------------------------------
// srrw_front
// takes one frame at a time and classifies it against the current window
// ----------------------------------------------------------------------------
`default_nettype none

module srrw_front #(
  parameter int WINDOW_SIZE = 4
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_stall_o,
  input  srrw_pkg::frame_t         in_word_i,
  input  srrw_pkg::win_status_t    status_i,
  input  wire  [WINDOW_SIZE-1:0]   slot_filled_i,
  input  wire                      q_full_i,
  output logic                     q_push_o,
  output srrw_pkg::q_entry_t       q_entry_o
);
  import srrw_pkg::*;

  localparam int SLOT_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;

  logic              busy_q, busy_d;
  logic [SLOT_W-1:0] slot_lut [SEQ_SPACE];
  logic [SEQ_W-1:0]  dist_x;
  logic [SEQ_W-1:0]  dist_h;
  logic              in_win;

  for (genvar v = 0; v < SEQ_SPACE; v++) begin : g_lut
    assign slot_lut[v] = SLOT_W'(v % WINDOW_SIZE);
  end

  assign dist_x = in_word_i.seq_number - status_i.expected_seq;
  assign dist_h = status_i.window_end - status_i.expected_seq;
  assign in_win = dist_x < dist_h;

  assign in_stall_o = busy_q || q_full_i;
  assign q_push_o   = in_valid_i && !in_stall_o;

  always_comb begin
    q_entry_o.accepted = in_win && !slot_filled_i[slot_lut[in_word_i.seq_number]];
    q_entry_o.seq      = in_word_i.seq_number;
    q_entry_o.data     = in_word_i.payload;
  end

  // one frame in flight until the window state is final
  always_comb begin
    busy_d = busy_q;
    if (status_i.frame_done) begin
      busy_d = 1'b0;
    end
    if (q_push_o) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/srrw_queue.sv =====
// ----------------------------------------------------------------------------
// srrw_queue
// short fifo of classified frames between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module srrw_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  srrw_pkg::q_entry_t   entry_i,
  output logic                 full_o,
  input  wire                  pop_i,
  output logic                 valid_o,
  output srrw_pkg::q_entry_t   entry_o
);
  import srrw_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t         fifo_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = count_q == CNT_W'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign entry_o = fifo_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      fifo_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/srrw_back.sv =====
// ----------------------------------------------------------------------------
// srrw_back
// window state, reorder store and in-order release sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module srrw_back #(
  parameter int WINDOW_SIZE = 4
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      q_valid_i,
  input  srrw_pkg::q_entry_t       q_entry_i,
  output logic                     q_pop_o,
  output srrw_pkg::win_status_t    status_o,
  output logic [WINDOW_SIZE-1:0]   slot_filled_o,
  output logic                     out_valid_o,
  input  wire                      out_stall_i,
  output srrw_pkg::result_t        out_word_o
);
  import srrw_pkg::*;

  localparam int SLOT_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [SLOT_W-1:0]      slot_lut [SEQ_SPACE];
  logic [BYTE_W-1:0]      store_mem [WINDOW_SIZE];

  logic [1:0]             state_q, state_d;
  logic [SEQ_W-1:0]       expected_q, expected_d;
  logic [SEQ_W-1:0]       window_end_q, window_end_d;
  logic [WINDOW_SIZE-1:0] filled_q, filled_d;
  logic [SEQ_W-1:0]       ack_q, ack_d;
  logic                   acc_q, acc_d;
  logic                   emit_data_q, emit_data_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [CNT_W-1:0]       left_q, left_d;
  logic [SEQ_W-1:0]       rd_seq_q, rd_seq_d;
  logic [BYTE_W-1:0]      rd_data_q;
  logic                   out_valid_q, out_valid_d;
  result_t                out_word_q, out_word_d;

  logic                   mem_we;
  logic                   mem_re;
  logic [SLOT_W-1:0]      in_slot;
  logic [SLOT_W-1:0]      exp_slot;
  logic [SLOT_W-1:0]      rd_slot;
  logic                   out_free;
  logic                   frame_done;

  for (genvar v = 0; v < SEQ_SPACE; v++) begin : g_lut
    assign slot_lut[v] = SLOT_W'(v % WINDOW_SIZE);
  end

  assign in_slot  = slot_lut[q_entry_i.seq];
  assign exp_slot = slot_lut[expected_q];
  assign rd_slot  = slot_lut[rd_seq_q];
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    expected_d   = expected_q;
    window_end_d = window_end_q;
    filled_d     = filled_q;
    ack_d        = ack_q;
    acc_d        = acc_q;
    emit_data_d  = emit_data_q;
    cnt_d        = cnt_q;
    left_d       = left_q;
    rd_seq_d     = rd_seq_q;
    out_valid_d  = out_valid_q;
    out_word_d   = out_word_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    q_pop_o      = 1'b0;
    frame_done   = 1'b0;

    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_entry_i.accepted) begin
            mem_we            = 1'b1;
            filled_d[in_slot] = 1'b1;
            cnt_d             = '0;
            rd_seq_d          = expected_q;
            state_d           = ST_SCAN;
          end else begin
            ack_d       = expected_q - 1'b1;
            acc_d       = 1'b0;
            emit_data_d = 1'b0;
            frame_done  = 1'b1;
            state_d     = ST_EMIT;
          end
        end
      end
      ST_SCAN: begin
        // walk the run of filled slots, one per cycle
        if (cnt_q != CNT_W'(WINDOW_SIZE) && filled_q[exp_slot]) begin
          filled_d[exp_slot] = 1'b0;
          expected_d         = expected_q + 1'b1;
          window_end_d       = window_end_q + 1'b1;
          cnt_d              = cnt_q + 1'b1;
        end else begin
          frame_done = 1'b1;
          ack_d      = expected_q - 1'b1;
          acc_d      = 1'b1;
          left_d     = cnt_q;
          if (cnt_q == '0) begin
            emit_data_d = 1'b0;
            state_d     = ST_EMIT;
          end else begin
            emit_data_d = 1'b1;
            state_d     = ST_READ;
          end
        end
      end
      ST_READ: begin
        mem_re  = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d              = 1'b1;
          out_word_d.accepted      = acc_q;
          out_word_d.ack_number    = ack_q;
          if (emit_data_q) begin
            out_word_d.deliver_valid = 1'b1;
            out_word_d.deliver_byte  = rd_data_q;
            out_word_d.last          = left_q == CNT_W'(1);
            rd_seq_d                 = rd_seq_q + 1'b1;
            left_d                   = left_q - 1'b1;
            state_d                  = (left_q == CNT_W'(1)) ? ST_IDLE : ST_READ;
          end else begin
            out_word_d.deliver_valid = 1'b0;
            out_word_d.deliver_byte  = '0;
            out_word_d.last          = 1'b1;
            state_d                  = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // reorder store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[in_slot] <= q_entry_i.data;
    end
    if (mem_re) begin
      rd_data_q <= store_mem[rd_slot];
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      expected_q   <= '0;
      window_end_q <= SEQ_W'(WINDOW_SIZE % SEQ_SPACE);
      filled_q     <= '0;
      ack_q        <= '0;
      acc_q        <= 1'b0;
      emit_data_q  <= 1'b0;
      cnt_q        <= '0;
      left_q       <= '0;
      rd_seq_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      expected_q   <= expected_d;
      window_end_q <= window_end_d;
      filled_q     <= filled_d;
      ack_q        <= ack_d;
      acc_q        <= acc_d;
      emit_data_q  <= emit_data_d;
      cnt_q        <= cnt_d;
      left_q       <= left_d;
      rd_seq_q     <= rd_seq_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_comb begin
    status_o.expected_seq = expected_q;
    status_o.window_end   = window_end_q;
    status_o.frame_done   = frame_done;
  end

  assign slot_filled_o = filled_q;
  assign out_valid_o   = out_valid_q;
  assign out_word_o    = out_word_q;

endmodule

`default_nettype wire
